// ----- hw/rtl/filtered_hysteresis_thermostat_core_assert.svh -----
// assertion macros for the thermostat core
`ifndef FILTERED_HYSTERESIS_THERMOSTAT_CORE_ASSERT_SVH
`define FILTERED_HYSTERESIS_THERMOSTAT_CORE_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define FHT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("thermostat core assertion failed");
// next-cycle implication
`define FHT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("thermostat core assertion failed");
`else
`define FHT_ASSERT_IMP(lbl, ante, cons)
`define FHT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- hw/rtl/fht_pkg.sv -----
`timescale 1ns / 1ps

package fht_pkg;

    localparam int DEPTH_DEFAULT = 10;

    localparam int SAMPLE_W   = 12;
    localparam int HYST_W     = 11;
    localparam int WARM_W     = 4;
    localparam int THR_W      = 13;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic signed [SAMPLE_W-1:0] SETPOINT_RST = 12'sd1120;
    localparam logic        [HYST_W-1:0]   HYST_RST     = 11'd48;
    localparam logic signed [SAMPLE_W-1:0] TRIP_RST     = 12'sd1360;
    localparam logic signed [SAMPLE_W-1:0] VMIN_RST     = -12'sd880;
    localparam logic signed [SAMPLE_W-1:0] VMAX_RST     = 12'sd2000;
    localparam logic        [WARM_W-1:0]   WARM_RST     = 4'd10;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT       = 3'd0,
        REG_HYSTERESIS     = 3'd1,
        REG_TRIP_LIMIT     = 3'd2,
        REG_VALID_MIN      = 3'd3,
        REG_VALID_MAX      = 3'd4,
        REG_WARMUP_SAMPLES = 3'd5
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_READ,
        ST_PUSH,
        ST_CMP_TRIP,
        ST_CMP_LO,
        ST_CMP_HI,
        ST_APPLY,
        ST_DIV_INIT,
        ST_DIV,
        ST_DIV_FIX,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        THR_TRIP,
        THR_LO,
        THR_HI
    } thr_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     take_warm;
        logic     mark_rej;
        logic     ring_rd;
        logic     push;
        logic     cmp_en;
        thr_sel_t thr_sel;
        logic     apply;
        logic     div_init;
        logic     div_step;
        logic     div_fix;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic shutdown;
        logic warm_pending;
        logic sample_ok;
        logic warm_item;
        logic div_last;
    } dp_sts_t;

endpackage

// ----- hw/rtl/fht_intf.sv -----
`timescale 1ns / 1ps

interface fht_sensor_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [fht_pkg::SAMPLE_W-1:0]   sample;
    logic                                  sensor_fault;

    modport source (output valid, output sample, output sensor_fault, input ready);
    modport sink   (input valid, input sample, input sensor_fault, output ready);
endinterface

interface fht_result_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  heater_drive;
    logic signed [fht_pkg::SAMPLE_W-1:0]   filtered;
    logic                                  rejected;
    logic                                  tripped;
    logic                                  in_warmup;

    modport source (
        output valid, output heater_drive, output filtered, output rejected,
        output tripped, output in_warmup, input ready
    );
    modport sink (
        input valid, input heater_drive, input filtered, input rejected,
        input tripped, input in_warmup, output ready
    );
endinterface

interface fht_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fht_pkg::CFG_IDX_W-1:0]     index;
    logic [fht_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/fht_ctrl.sv -----
`timescale 1ns / 1ps

module fht_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  fht_pkg::dp_sts_t sts,
    output fht_pkg::dp_cmd_t cmd
);

    fht_pkg::state_t state_reg;
    fht_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fht_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = fht_pkg::ST_DECIDE;
                end
            end
            fht_pkg::ST_DECIDE:
            begin
                priority if (sts.shutdown)
                begin
                    state_next = fht_pkg::ST_DONE;
                end
                else if (sts.warm_pending)
                begin
                    state_next = fht_pkg::ST_READ;
                end
                else if (!sts.sample_ok)
                begin
                    state_next = fht_pkg::ST_DONE;
                end
                else
                begin
                    state_next = fht_pkg::ST_READ;
                end
            end
            fht_pkg::ST_READ:     state_next = fht_pkg::ST_PUSH;
            fht_pkg::ST_PUSH:
            begin
                state_next = sts.warm_item ? fht_pkg::ST_DIV_INIT : fht_pkg::ST_CMP_TRIP;
            end
            fht_pkg::ST_CMP_TRIP: state_next = fht_pkg::ST_CMP_LO;
            fht_pkg::ST_CMP_LO:   state_next = fht_pkg::ST_CMP_HI;
            fht_pkg::ST_CMP_HI:   state_next = fht_pkg::ST_APPLY;
            fht_pkg::ST_APPLY:    state_next = fht_pkg::ST_DIV_INIT;
            fht_pkg::ST_DIV_INIT: state_next = fht_pkg::ST_DIV;
            fht_pkg::ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = fht_pkg::ST_DIV_FIX;
                end
            end
            fht_pkg::ST_DIV_FIX:  state_next = fht_pkg::ST_DONE;
            fht_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = fht_pkg::ST_IDLE;
                end
            end
            default:              state_next = fht_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            fht_pkg::ST_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_in  = in_valid;
            end
            fht_pkg::ST_DECIDE:
            begin
                if (!sts.shutdown)
                begin
                    cmd.take_warm = sts.warm_pending;
                    cmd.mark_rej  = !sts.warm_pending && !sts.sample_ok;
                end
            end
            fht_pkg::ST_READ:     cmd.ring_rd = 1'b1;
            fht_pkg::ST_PUSH:     cmd.push = 1'b1;
            fht_pkg::ST_CMP_TRIP:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.thr_sel = fht_pkg::THR_TRIP;
            end
            fht_pkg::ST_CMP_LO:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.thr_sel = fht_pkg::THR_LO;
            end
            fht_pkg::ST_CMP_HI:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.thr_sel = fht_pkg::THR_HI;
            end
            fht_pkg::ST_APPLY:    cmd.apply = 1'b1;
            fht_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
            fht_pkg::ST_DIV:      cmd.div_step = 1'b1;
            fht_pkg::ST_DIV_FIX:  cmd.div_fix = 1'b1;
            fht_pkg::ST_DONE:     cmd.out_load = out_free;
            default:              cmd = '0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fht_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- hw/rtl/fht_dp.sv -----
`timescale 1ns / 1ps

module fht_dp #(
    parameter int DEPTH = fht_pkg::DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fht_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fht_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic signed [fht_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 sensor_fault,
    input  fht_pkg::dp_cmd_t                     cmd,
    output fht_pkg::dp_sts_t                     sts,
    output logic                                 heater_drive,
    output logic signed [fht_pkg::SAMPLE_W-1:0]  filtered,
    output logic                                 rejected,
    output logic                                 tripped,
    output logic                                 in_warmup
);

    localparam int SW     = fht_pkg::SAMPLE_W;
    localparam int SUM_W  = SW + $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIVC_W = $clog2(SUM_W);
    localparam int PROD_W = fht_pkg::THR_W + CNT_W + 1;

    // configuration
    logic signed [SW-1:0]                     setpoint_reg;
    logic        [fht_pkg::HYST_W-1:0]        hyst_reg;
    logic signed [SW-1:0]                     trip_reg;
    logic signed [SW-1:0]                     vmin_reg;
    logic signed [SW-1:0]                     vmax_reg;

    // filter and control state
    logic signed [SW-1:0]                     ring [DEPTH];
    logic        [SLOT_W-1:0]                 slot_reg;
    logic        [SLOT_W-1:0]                 slot_next;
    logic                                     full_reg;
    logic                                     full_next;
    logic signed [SUM_W-1:0]                  sum_reg;
    logic signed [SUM_W-1:0]                  sum_next;
    logic        [fht_pkg::WARM_W-1:0]        warm_left_reg;
    logic                                     heater_reg;
    logic                                     shutdown_reg;
    logic signed [SW-1:0]                     avg_reg;

    // per-item working registers
    logic signed [SW-1:0]                     sample_reg;
    logic                                     fault_reg;
    logic signed [SW-1:0]                     old_reg;
    logic                                     rej_item_reg;
    logic                                     warm_item_reg;
    logic                                     trip_gt_reg;
    logic                                     lo_lt_reg;
    logic                                     hi_gt_reg;

    // divider
    logic        [CNT_W-1:0]                  rem_reg;
    logic        [CNT_W-1:0]                  rem_next;
    logic        [SUM_W-1:0]                  quo_reg;
    logic        [SUM_W-1:0]                  quo_next;
    logic                                     neg_reg;
    logic        [DIVC_W-1:0]                 divcnt_reg;
    logic        [CNT_W:0]                    trial;
    logic        [CNT_W:0]                    diff;
    logic                                     ge;
    logic        [SUM_W-1:0]                  sum_mag;
    logic        [SW-1:0]                     q_mag;

    // result register
    logic                                     res_heater_reg;
    logic signed [SW-1:0]                     res_filtered_reg;
    logic                                     res_rejected_reg;
    logic                                     res_tripped_reg;
    logic                                     res_warm_reg;

    logic        [CNT_W-1:0]                  count;
    logic signed [fht_pkg::THR_W-1:0]         thr;
    logic signed [PROD_W-1:0]                 thr_x;
    logic signed [PROD_W-1:0]                 cnt_x;
    logic signed [PROD_W-1:0]                 prod;
    logic signed [PROD_W-1:0]                 sum_x;
    logic signed [SUM_W:0]                    acc;

    assign count = full_reg ? CNT_W'(DEPTH) : CNT_W'(slot_reg);

    assign sts.shutdown     = shutdown_reg;
    assign sts.warm_pending = (warm_left_reg != '0);
    assign sts.sample_ok    = !fault_reg && (sample_reg >= vmin_reg) && (sample_reg <= vmax_reg);
    assign sts.warm_item    = warm_item_reg;
    assign sts.div_last     = (divcnt_reg == DIVC_W'(SUM_W - 1));

    // ring update
    always_comb
    begin
        acc = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(sample_reg);
        if (full_reg)
        begin
            acc = acc - (SUM_W + 1)'(old_reg);
        end
        sum_next  = acc[SUM_W-1:0];
        full_next = full_reg;
        if (slot_reg == SLOT_W'(DEPTH - 1))
        begin
            slot_next = '0;
            full_next = 1'b1;
        end
        else
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end
    end

    // threshold times count
    always_comb
    begin
        unique case (cmd.thr_sel)
            fht_pkg::THR_TRIP: thr = fht_pkg::THR_W'(trip_reg);
            fht_pkg::THR_LO:
                thr = fht_pkg::THR_W'(setpoint_reg) - signed'(fht_pkg::THR_W'(hyst_reg));
            fht_pkg::THR_HI:
                thr = fht_pkg::THR_W'(setpoint_reg) + signed'(fht_pkg::THR_W'(hyst_reg));
            default:           thr = fht_pkg::THR_W'(trip_reg);
        endcase
        thr_x = PROD_W'(thr);
        cnt_x = signed'(PROD_W'(count));
        prod  = thr_x * cnt_x;
        sum_x = PROD_W'(sum_reg);
    end

    // restoring divide step, one quotient bit per cycle
    always_comb
    begin
        sum_mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        trial    = {rem_reg, quo_reg[SUM_W-1]};
        diff     = trial - {1'b0, count};
        ge       = (trial >= {1'b0, count});
        rem_next = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo_next = {quo_reg[SUM_W-2:0], ge};
        q_mag    = quo_reg[SW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= fht_pkg::SETPOINT_RST;
            hyst_reg      <= fht_pkg::HYST_RST;
            trip_reg      <= fht_pkg::TRIP_RST;
            vmin_reg      <= fht_pkg::VMIN_RST;
            vmax_reg      <= fht_pkg::VMAX_RST;
            warm_left_reg <= fht_pkg::WARM_RST;
            slot_reg      <= '0;
            full_reg      <= 1'b0;
            sum_reg       <= '0;
            heater_reg    <= 1'b1;
            shutdown_reg  <= 1'b0;
            avg_reg       <= '0;
            divcnt_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    fht_pkg::REG_SETPOINT:       setpoint_reg  <= cfg_data;
                    fht_pkg::REG_HYSTERESIS:     hyst_reg      <= cfg_data[fht_pkg::HYST_W-1:0];
                    fht_pkg::REG_TRIP_LIMIT:     trip_reg      <= cfg_data;
                    fht_pkg::REG_VALID_MIN:      vmin_reg      <= cfg_data;
                    fht_pkg::REG_VALID_MAX:      vmax_reg      <= cfg_data;
                    fht_pkg::REG_WARMUP_SAMPLES:
                        warm_left_reg <= cfg_data[fht_pkg::WARM_W-1:0];
                    default:                     ;
                endcase
            end
            else if (cmd.take_warm)
            begin
                warm_left_reg <= warm_left_reg - fht_pkg::WARM_W'(1);
                heater_reg    <= 1'b1;
            end
            if (cmd.push)
            begin
                slot_reg <= slot_next;
                full_reg <= full_next;
                sum_reg  <= sum_next;
            end
            if (cmd.apply)
            begin
                priority if (trip_gt_reg)
                begin
                    shutdown_reg <= 1'b1;
                    heater_reg   <= 1'b0;
                end
                else if (!heater_reg && lo_lt_reg)
                begin
                    heater_reg <= 1'b1;
                end
                else if (heater_reg && hi_gt_reg)
                begin
                    heater_reg <= 1'b0;
                end
                else
                begin
                    heater_reg <= heater_reg;
                end
            end
            if (cmd.div_init)
            begin
                divcnt_reg <= '0;
            end
            else if (cmd.div_step)
            begin
                divcnt_reg <= divcnt_reg + DIVC_W'(1);
            end
            if (cmd.div_fix)
            begin
                avg_reg <= neg_reg ? signed'(-q_mag) : signed'(q_mag);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ring_rd)
        begin
            old_reg <= ring[slot_reg];
        end
        if (cmd.push)
        begin
            ring[slot_reg] <= sample_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            sample_reg    <= sample;
            fault_reg     <= sensor_fault;
            rej_item_reg  <= 1'b0;
            warm_item_reg <= 1'b0;
        end
        if (cmd.take_warm)
        begin
            warm_item_reg <= 1'b1;
        end
        if (cmd.mark_rej)
        begin
            rej_item_reg <= 1'b1;
        end
        if (cmd.cmp_en)
        begin
            unique case (cmd.thr_sel)
                fht_pkg::THR_TRIP: trip_gt_reg <= (sum_x > prod);
                fht_pkg::THR_LO:   lo_lt_reg   <= (sum_x < prod);
                fht_pkg::THR_HI:   hi_gt_reg   <= (sum_x > prod);
                default:           trip_gt_reg <= (sum_x > prod);
            endcase
        end
        if (cmd.div_init)
        begin
            rem_reg <= '0;
            quo_reg <= sum_mag;
            neg_reg <= sum_reg[SUM_W-1];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            res_heater_reg   <= heater_reg;
            res_filtered_reg <= avg_reg;
            res_rejected_reg <= rej_item_reg;
            res_tripped_reg  <= shutdown_reg;
            res_warm_reg     <= warm_item_reg;
        end
    end

    assign heater_drive = res_heater_reg;
    assign filtered     = res_filtered_reg;
    assign rejected     = res_rejected_reg;
    assign tripped      = res_tripped_reg;
    assign in_warmup    = res_warm_reg;

endmodule

// ----- hw/rtl/filtered_hysteresis_thermostat_core.sv -----
`timescale 1ns / 1ps
// channel   modport  payload                                             width
// sensor    sink     sample, sensor_fault                                12s, 1
// result    source   heater_drive, filtered, rejected, tripped, in_warmup 1, 12s, 1, 1, 1
// cfg       sink     index, data                                         3, 12
//
// a rejected sample or an input after shutdown goes from DECIDE straight to DONE
// an accepted sample passes READ, PUSH, CMP_TRIP, CMP_LO, CMP_HI, APPLY, DIV_INIT, DIV, DIV_FIX and DONE;
// warmup samples skip the compares and APPLY; in DIV the bit-serial divider forms the average over
// SUM_W = 12 + clog2(DEPTH) bits; the result sits in an output register, so the next sample is taken while it waits
// rst_n is asynchronous; no clearing pass, ring entries are read only once written
// cfg is always ready; it must be written only while no sample is in flight, the core does not check this

`include "filtered_hysteresis_thermostat_core_assert.svh"

module filtered_hysteresis_thermostat_core #(
    parameter int DEPTH = fht_pkg::DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    fht_sensor_if.sink   sensor,
    fht_result_if.source result,
    fht_cfg_if.sink      cfg
);

    fht_pkg::dp_cmd_t cmd;
    fht_pkg::dp_sts_t sts;

    assign cfg.ready = 1'b1;

    fht_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sensor.valid),
        .in_ready  (sensor.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fht_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg.valid),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .sample       (sensor.sample),
        .sensor_fault (sensor.sensor_fault),
        .cmd          (cmd),
        .sts          (sts),
        .heater_drive (result.heater_drive),
        .filtered     (result.filtered),
        .rejected     (result.rejected),
        .tripped      (result.tripped),
        .in_warmup    (result.in_warmup)
    );

    `FHT_ASSERT_NEXT(a_latch_holds, sts.shutdown, sts.shutdown)
    `FHT_ASSERT_NEXT(a_busy_after_transfer, sensor.valid && sensor.ready, !sensor.ready)
    `FHT_ASSERT_IMP(a_trip_heater_off, result.valid && result.tripped, !result.heater_drive)
    `FHT_ASSERT_IMP(a_warm_clean, result.valid && result.in_warmup, !result.rejected && !result.tripped)

endmodule
